[rtl/core/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation codes and divider request/response types for the
// rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPW = 32;               // operand bits taken from each port
	localparam int W   = OPW + 1;          // internal signed width (holds -min/-1)
	localparam int RW  = 64;               // result width
	localparam int CW  = $clog2(W + 1);    // divider step counter width
	localparam int FW  = 3;                // operation code width

	localparam logic [FW-1:0] FN_ADD = 3'd0;
	localparam logic [FW-1:0] FN_SUB = 3'd1;
	localparam logic [FW-1:0] FN_MUL = 3'd2;
	localparam logic [FW-1:0] FN_DIV = 3'd3;
	localparam logic [FW-1:0] FN_RED = 3'd4;
	localparam logic [FW-1:0] FN_EQU = 3'd5;

	typedef struct packed {
		logic                start;
		logic signed [W-1:0] dvd;
		logic signed [W-1:0] dvs;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic signed [W-1:0] quo;
		logic signed [W-1:0] rem;
	} div_rsp_t;

	// take the low OPW bits of a port and sign-extend to the internal width
	function automatic logic signed [W-1:0] sext_w(input logic [31:0] v);
		return {{(W-OPW){v[OPW-1]}}, v[OPW-1:0]};
	endfunction

	function automatic logic signed [RW-1:0] ext_r(input logic signed [W-1:0] v);
		return {{(RW-W){v[W-1]}}, v};
	endfunction

endpackage

[rtl/core/rational_arith_unit_top.sv]
// ----------------------------------------------------------------------------
// rational_arith_unit_top
// Fraction add, subtract, multiply, divide, reduce and equivalence test on a
// shared iterative divider and a shared multiplier under a phase sequencer.
// ----------------------------------------------------------------------------
// Sequence: multiply/divide use only the multiplier; add/subtract with equal or
//   zero denominators use neither unit; otherwise a gcd costs K divisions plus
//   K+1 checks, K being Euclid's step count.
// Flow control: the block takes no request while a previous one is in flight or
//   waits to be taken.
// Reset: arst_n clears the sequencer and handshakes at once; no clearing pass.
// ----------------------------------------------------------------------------
module rational_arith_unit_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rau_pkg::FW-1:0]        func,
	input  logic signed [31:0]            a_num,
	input  logic signed [31:0]            a_den,
	input  logic signed [31:0]            b_num,
	input  logic signed [31:0]            b_den,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [rau_pkg::RW-1:0] res_num,
	output logic signed [rau_pkg::RW-1:0] res_den,
	output logic                          equivalent,
	output logic                          zero_fault
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DISP  = 7'b0000010,
		S_GCD   = 7'b0000100,
		S_GWAIT = 7'b0001000,
		S_DWAIT = 7'b0010000,
		S_MUL   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t                         state_q;
	logic [2:0]                     ph_q;     // step within the current operation
	logic                           pass_q;   // equivalence: 0 first fraction, 1 second
	logic [rau_pkg::FW-1:0]         func_q;

	logic signed [rau_pkg::W-1:0]   an_q, ad_q, bn_q, bd_q;
	logic signed [rau_pkg::W-1:0]   x_q, y_q;     // Euclid pair; x_q ends as the gcd
	logic signed [rau_pkg::W-1:0]   fa_q, fb_q;   // scale factors or saved reduced a
	logic signed [rau_pkg::W-1:0]   cn_q, cd_q;   // fraction under reduction
	logic signed [rau_pkg::W-1:0]   ma_q, mb_q;   // multiplier operands
	logic signed [rau_pkg::RW-1:0]  rn_q, rd_q;
	logic                           eq_q, flt_q;

	logic                           div_start_q;
	logic signed [rau_pkg::W-1:0]   div_dvd_q, div_dvs_q;
	rau_pkg::div_req_t              div_req;
	rau_pkg::div_rsp_t              div_rsp;
	logic signed [rau_pkg::RW-1:0]  prod;

	assign div_req = {div_start_q, div_dvd_q, div_dvs_q};

	rau_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rau_mul u_mul (
		.clk  (clk),
		.a    (ma_q),
		.b    (mb_q),
		.prod (prod)
	);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign res_num    = rn_q;
	assign res_den    = rd_q;
	assign equivalent = eq_q;
	assign zero_fault = flt_q;

	// control: sequencer state, phase, divider start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= '0;
			pass_q      <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
						ph_q    <= '0;
						pass_q  <= 1'b0;
					end
				end
				S_DISP: begin
					case (func_q)
						rau_pkg::FN_ADD, rau_pkg::FN_SUB: begin
							case (ph_q)
								3'd0: begin
									if (ad_q == bd_q || ad_q == '0 || bd_q == '0) begin
										state_q <= S_OUT;
									end else begin
										state_q <= S_GCD;
										ph_q    <= 3'd1;
									end
								end
								3'd1, 3'd2: begin
									div_start_q <= 1'b1;
									state_q     <= S_DWAIT;
									ph_q        <= ph_q + 3'd1;
								end
								3'd3, 3'd4, 3'd5: begin
									state_q <= S_MUL;
									ph_q    <= ph_q + 3'd1;
								end
								default: state_q <= S_OUT;
							endcase
						end
						rau_pkg::FN_MUL, rau_pkg::FN_DIV: begin
							if (ph_q == 3'd2) begin
								state_q <= S_OUT;
							end else begin
								state_q <= S_MUL;
								ph_q    <= ph_q + 3'd1;
							end
						end
						rau_pkg::FN_RED, rau_pkg::FN_EQU: begin
							case (ph_q)
								3'd0: begin
									state_q <= S_GCD;
									ph_q    <= 3'd1;
								end
								3'd1: begin
									if (x_q == '0) begin
										ph_q <= 3'd4;
									end else begin
										div_start_q <= 1'b1;
										state_q     <= S_DWAIT;
										ph_q        <= 3'd2;
									end
								end
								3'd2: begin
									div_start_q <= 1'b1;
									state_q     <= S_DWAIT;
									ph_q        <= 3'd3;
								end
								3'd3: ph_q <= 3'd4;
								default: begin
									if (func_q == rau_pkg::FN_EQU && !pass_q) begin
										pass_q  <= 1'b1;
										state_q <= S_GCD;
										ph_q    <= 3'd1;
									end else begin
										state_q <= S_OUT;
									end
								end
							endcase
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_GCD: begin
					// Euclid ends when the divisor reaches zero
					if (y_q == '0) begin
						state_q <= S_DISP;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= S_GWAIT;
					end
				end
				S_GWAIT: begin
					if (div_rsp.done) state_q <= S_GCD;
				end
				S_DWAIT: begin
					if (div_rsp.done) state_q <= S_DISP;
				end
				S_MUL: state_q <= S_DISP;
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					func_q <= func;
					an_q   <= rau_pkg::sext_w(a_num);
					ad_q   <= rau_pkg::sext_w(a_den);
					bn_q   <= rau_pkg::sext_w(b_num);
					bd_q   <= rau_pkg::sext_w(b_den);
					rn_q   <= '0;
					rd_q   <= '0;
					eq_q   <= 1'b0;
					flt_q  <= 1'b0;
				end
			end
			S_DISP: begin
				case (func_q)
					rau_pkg::FN_ADD, rau_pkg::FN_SUB: begin
						case (ph_q)
							3'd0: begin
								if (ad_q == bd_q) begin
									// common denominator: plain wide sum or difference
									rn_q  <= (func_q == rau_pkg::FN_ADD)
									         ? rau_pkg::ext_r(an_q) + rau_pkg::ext_r(bn_q)
									         : rau_pkg::ext_r(an_q) - rau_pkg::ext_r(bn_q);
									rd_q  <= rau_pkg::ext_r(ad_q);
									flt_q <= (ad_q == '0);
								end else if (ad_q == '0 || bd_q == '0) begin
									flt_q <= 1'b1;
								end else begin
									x_q <= ad_q;
									y_q <= bd_q;
								end
							end
							3'd1: begin
								div_dvd_q <= bd_q;
								div_dvs_q <= x_q;
							end
							3'd2: begin
								fa_q      <= div_rsp.quo;
								div_dvd_q <= ad_q;
								div_dvs_q <= x_q;
							end
							3'd3: begin
								fb_q <= div_rsp.quo;
								ma_q <= fa_q;
								mb_q <= an_q;
							end
							3'd4: begin
								rn_q <= prod;
								ma_q <= fb_q;
								mb_q <= bn_q;
							end
							3'd5: begin
								rn_q <= (func_q == rau_pkg::FN_ADD) ? rn_q + prod : rn_q - prod;
								ma_q <= fa_q;
								mb_q <= ad_q;
							end
							default: rd_q <= prod;
						endcase
					end
					rau_pkg::FN_MUL, rau_pkg::FN_DIV: begin
						case (ph_q)
							3'd0: begin
								ma_q <= an_q;
								mb_q <= (func_q == rau_pkg::FN_MUL) ? bn_q : bd_q;
							end
							3'd1: begin
								rn_q <= prod;
								ma_q <= ad_q;
								mb_q <= (func_q == rau_pkg::FN_MUL) ? bd_q : bn_q;
							end
							default: begin
								rd_q  <= prod;
								flt_q <= (prod == '0);
							end
						endcase
					end
					rau_pkg::FN_RED, rau_pkg::FN_EQU: begin
						case (ph_q)
							3'd0: begin
								cn_q <= an_q;
								cd_q <= ad_q;
								x_q  <= an_q;
								y_q  <= ad_q;
							end
							3'd1: begin
								if (x_q == '0) begin
									// zero gcd: both parts zero, result is 0/0
									cn_q  <= '0;
									cd_q  <= '0;
									flt_q <= 1'b1;
								end else begin
									flt_q     <= flt_q | (cd_q == '0);
									div_dvd_q <= cn_q;
									div_dvs_q <= x_q;
								end
							end
							3'd2: begin
								cn_q      <= div_rsp.quo;
								div_dvd_q <= cd_q;
								div_dvs_q <= x_q;
							end
							3'd3: cd_q <= div_rsp.quo;
							default: begin
								if (func_q == rau_pkg::FN_EQU && !pass_q) begin
									// hold reduced first fraction, start on the second
									fa_q <= cn_q;
									fb_q <= cd_q;
									cn_q <= bn_q;
									cd_q <= bd_q;
									x_q  <= bn_q;
									y_q  <= bd_q;
								end else if (func_q == rau_pkg::FN_EQU) begin
									eq_q <= (cn_q == fa_q) && (cd_q == fb_q);
									rn_q <= rau_pkg::ext_r(fa_q);
									rd_q <= rau_pkg::ext_r(fb_q);
								end else begin
									rn_q <= rau_pkg::ext_r(cn_q);
									rd_q <= rau_pkg::ext_r(cd_q);
								end
							end
						endcase
					end
					default: begin
						rn_q <= '0;
						rd_q <= '0;
					end
				endcase
			end
			S_GCD: begin
				if (y_q != '0) begin
					div_dvd_q <= x_q;
					div_dvs_q <= y_q;
				end
			end
			S_GWAIT: begin
				// advance the Euclid pair
				if (div_rsp.done) begin
					x_q <= y_q;
					y_q <= div_rsp.rem;
				end
			end
			default: begin
			end
		endcase
	end

	// no request is taken while one is in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while busy");

	// divider results arrive only while the sequencer waits for them
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_GWAIT || state_q == S_DWAIT))
		else $error("divider result outside a wait state");

	// the equivalence flag comes only from an equivalence request
	a_eq_func: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && equivalent) |-> (func_q == rau_pkg::FN_EQU))
		else $error("equivalent set for another operation");

	// the divider is never started with a zero divisor
	a_div_nz: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> (div_dvs_q != '0))
		else $error("divide by zero issued");

endmodule

[rtl/core/rau_div.sv]
// ----------------------------------------------------------------------------
// rau_div
// Iterative signed divider, one quotient bit per cycle, truncating quotient
// and remainder carrying the sign of the dividend.
// ----------------------------------------------------------------------------
module rau_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rau_pkg::div_req_t   req,
	output rau_pkg::div_rsp_t   rsp
);

	logic                      busy_q;
	logic [rau_pkg::CW-1:0]    cnt_q;
	logic [rau_pkg::W-1:0]     rem_q;
	logic [rau_pkg::W-1:0]     quo_q;
	logic [rau_pkg::W-1:0]     dvs_q;
	logic                      qneg_q;
	logic                      rneg_q;
	logic                      done_q;
	logic signed [rau_pkg::W-1:0] qout_q;
	logic signed [rau_pkg::W-1:0] rout_q;

	logic [rau_pkg::W:0]   rem_sh;
	logic [rau_pkg::W:0]   diff;
	logic [rau_pkg::W-1:0] dvd_mag;
	logic [rau_pkg::W-1:0] dvs_mag;

	always_comb begin
		dvd_mag = req.dvd[rau_pkg::W-1] ? rau_pkg::W'(-req.dvd) : rau_pkg::W'(req.dvd);
		dvs_mag = req.dvs[rau_pkg::W-1] ? rau_pkg::W'(-req.dvs) : rau_pkg::W'(req.dvs);
		rem_sh  = {rem_q, quo_q[rau_pkg::W-1]};
		diff    = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= rau_pkg::CW'(rau_pkg::W);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath: restoring shift-subtract on magnitudes
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quo_q  <= dvd_mag;
			dvs_q  <= dvs_mag;
			qneg_q <= req.dvd[rau_pkg::W-1] ^ req.dvs[rau_pkg::W-1];
			rneg_q <= req.dvd[rau_pkg::W-1];
		end else if (busy_q && cnt_q != '0) begin
			if (!diff[rau_pkg::W]) begin
				rem_q <= diff[rau_pkg::W-1:0];
				quo_q <= {quo_q[rau_pkg::W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[rau_pkg::W-1:0];
				quo_q <= {quo_q[rau_pkg::W-2:0], 1'b0};
			end
		end else if (busy_q) begin
			qout_q <= qneg_q ? -$signed(quo_q) : $signed(quo_q);
			rout_q <= rneg_q ? -$signed(rem_q) : $signed(rem_q);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = qout_q;
	assign rsp.rem  = rout_q;

endmodule

[rtl/core/rau_mul.sv]
// ----------------------------------------------------------------------------
// rau_mul
// Shared signed multiplier with a registered product, truncated to the
// result width.
// ----------------------------------------------------------------------------
module rau_mul (
	input  logic                          clk,
	input  logic signed [rau_pkg::W-1:0]  a,
	input  logic signed [rau_pkg::W-1:0]  b,
	output logic signed [rau_pkg::RW-1:0] prod
);

	logic signed [2*rau_pkg::W-1:0] full;
	logic signed [rau_pkg::RW-1:0]  prod_q;

	assign full = a * b;

	always_ff @(posedge clk) begin
		prod_q <= full[rau_pkg::RW-1:0];
	end

	assign prod = prod_q;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives random and directed fraction requests through the valid/ready input,
// predicts each result in a scoreboard and compares every returned fraction
// and flag, with random gaps and a long receiver hold-off.
// ----------------------------------------------------------------------------
typedef struct {
	logic [rau_pkg::FW-1:0] fn;
	logic signed [31:0] an, ad, bn, bd;
} frac_req_t;

typedef struct {
	logic signed [63:0] num, den;
	logic               eq, fault;
} frac_res_t;

class frac_scoreboard;
	frac_res_t pending[$];
	int        errors;

	// truncating Euclid, as the block computes it
	function automatic longint tgcd(longint x, longint y);
		longint t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic bit reduce(ref longint n, ref longint d);
		longint g;
		bit     f;
		g = tgcd(n, d);
		f = (d == 0);
		if (g == 0) begin
			n = 0;
			d = 0;
			return 1;
		end
		n = n / g;
		d = d / g;
		return f;
	endfunction

	function void note_request(frac_req_t r);
		frac_res_t e;
		longint    an, ad, bn, bd, g, fa, fb;
		an = r.an; ad = r.ad; bn = r.bn; bd = r.bd;
		e = '{default: 0};
		case (r.fn)
			rau_pkg::FN_ADD, rau_pkg::FN_SUB: begin
				if (ad == bd) begin
					e.num = (r.fn == rau_pkg::FN_ADD) ? an + bn : an - bn;
					e.den = ad;
					e.fault = (ad == 0);
				end else if (ad == 0 || bd == 0) begin
					e.fault = 1;
				end else begin
					g = tgcd(ad, bd);
					fa = bd / g;
					fb = ad / g;
					e.num = (r.fn == rau_pkg::FN_ADD) ? fa * an + fb * bn : fa * an - fb * bn;
					e.den = fa * ad;
				end
			end
			rau_pkg::FN_MUL: begin
				e.num = an * bn;
				e.den = ad * bd;
				e.fault = (e.den == 0);
			end
			rau_pkg::FN_DIV: begin
				e.num = an * bd;
				e.den = ad * bn;
				e.fault = (e.den == 0);
			end
			rau_pkg::FN_RED: begin
				e.fault = reduce(an, ad);
				e.num = an;
				e.den = ad;
			end
			rau_pkg::FN_EQU: begin
				e.fault = reduce(an, ad);
				e.fault = reduce(bn, bd) | e.fault;
				e.eq = (an == bn) && (ad == bd);
				e.num = an;
				e.den = ad;
			end
			default: ;
		endcase
		pending.push_back(e);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("%0t: %s got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic check_result(frac_res_t r);
		frac_res_t e;
		if (pending.size() == 0) begin
			$display("%0t: result with nothing outstanding", $time);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (r.num !== e.num) report("res_num", r.num, e.num);
		if (r.den !== e.den) report("res_den", r.den, e.den);
		if (r.eq !== e.eq) report("equivalent", r.eq, e.eq);
		if (r.fault !== e.fault) report("zero_fault", r.fault, e.fault);
	endtask
endclass

module testbench;
	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [rau_pkg::FW-1:0] func = '0;
	logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [63:0] res_num, res_den;
	logic               equivalent, zero_fault;

	frac_scoreboard sb = new();
	int  cycles = 0;
	bit  hold_sink = 0;   // long receiver hold-off in progress

	localparam int CYCLE_LIMIT = 40_000_000;

	always #4 clk = ~clk;

	rational_arith_unit_top u_top (.*);

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 400);
	endfunction

	// random operand: extremes, small or shifted small values, or full range
	function automatic logic [31:0] operand();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3, 4, 5: return $urandom_range(0, 40) - 20;
			6: return ($urandom_range(1, 60) * ($urandom_range(0, 1) ? 1 : -1)) << $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	// offer one request and hold it until accepted
	task automatic send(frac_req_t r);
		in_valid <= 1;
		func <= r.fn;
		a_num <= r.an; a_den <= r.ad; b_num <= r.bn; b_den <= r.bd;
		do @(posedge clk); while (!in_ready);
		sb.note_request(r);
	endtask

	task automatic send_idle(frac_req_t r);
		int g;
		send(r);
		g = gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic frac_req_t mk(int fn, int an, int ad, int bn, int bd);
		frac_req_t r;
		r.fn = rau_pkg::FW'(fn); r.an = an; r.ad = ad; r.bn = bn; r.bd = bd;
		return r;
	endfunction

	// receiver: random stalls, sample at the edge where out_valid and out_ready meet
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = hold_sink ? 0 : gap();
			if (g > 0) begin
				out_ready <= 0;
				repeat (g) @(posedge clk);
			end
			out_ready <= !hold_sink;
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result('{res_num, res_den, equivalent, zero_fault});
		end
	end

	initial begin
		frac_req_t r;
		int        n;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, each operation, each special case
		send_idle(mk(rau_pkg::FN_ADD, 1, 3, 1, 3));
		send_idle(mk(rau_pkg::FN_SUB, 5, 0, 2, 0));        // equal zero denominators
		send_idle(mk(rau_pkg::FN_ADD, 1, 0, 1, 4));        // one zero denominator
		send_idle(mk(rau_pkg::FN_SUB, 1, 4, 1, 0));
		send_idle(mk(rau_pkg::FN_ADD, 1, 6, 1, -4));       // negative denominator
		send_idle(mk(rau_pkg::FN_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
		send_idle(mk(rau_pkg::FN_SUB, 32'h80000000, 32'h7fffffff, 32'h80000000, -1));
		send_idle(mk(rau_pkg::FN_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
		send_idle(mk(rau_pkg::FN_MUL, 3, 0, 4, 5));
		send_idle(mk(rau_pkg::FN_DIV, 32'h7fffffff, 3, 32'h80000000, -7));
		send_idle(mk(rau_pkg::FN_DIV, 1, 2, 0, 3));        // zero divisor numerator
		send_idle(mk(rau_pkg::FN_RED, 0, 0, 1, 1));        // gcd zero
		send_idle(mk(rau_pkg::FN_RED, 5, 0, 1, 1));        // positive over zero
		send_idle(mk(rau_pkg::FN_RED, -5, 0, 1, 1));       // negative over zero
		send_idle(mk(rau_pkg::FN_RED, 12, -18, 0, 0));
		send_idle(mk(rau_pkg::FN_RED, 32'h80000000, 32'h80000000, 0, 0));
		send_idle(mk(rau_pkg::FN_EQU, 2, 4, 1, 2));
		send_idle(mk(rau_pkg::FN_EQU, 2, 4, -1, -2));
		send_idle(mk(rau_pkg::FN_EQU, 0, 0, 3, 0));
		send_idle(mk(rau_pkg::FN_EQU, 32'h80000000, -1, 32'h7fffffff, 1));
		send_idle(mk(6, 1, 2, 3, 4));                      // unused codes
		send_idle(mk(7, -1, -1, -1, -1));

		// receiver holds off while the sender keeps offering
		hold_sink <= 1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_sink <= 0;
			end
			for (int i = 0; i < 4; i++)
				send(mk($urandom_range(0, 5), operand(), operand(), operand(), operand()));
		join
		in_valid <= 0;

		// random part, with one drain pause midway
		for (n = 0; n < 1900; n++) begin
			r = mk($urandom_range(0, 7), operand(), operand(), operand(), operand());
			if ($urandom_range(0, 3) == 0) r.bd = r.ad;  // equal-denominator path
			send_idle(r);
			if (n == 900) begin
				in_valid <= 0;
				wait (sb.pending.size() == 0);
				@(posedge clk);
			end
		end
		in_valid <= 0;

		wait (sb.pending.size() == 0);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

[sim.f]
rtl/core/rau_pkg.sv
rtl/core/rau_div.sv
rtl/core/rau_mul.sv
rtl/core/rational_arith_unit_top.sv
tb/sv/testbench.sv
